// File: hw/rtl/lsrf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the link speed request filter.
// No dependencies; imported by every module of the block.
package lsrf_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_TICK     = 3'd0,
		ST_AT_SPEED = 3'd1,
		ST_HELD     = 3'd2,
		ST_ISSUED   = 3'd3,
		ST_INVALID  = 3'd4
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_PORT_SPEEDS   = 2'd0;
	localparam logic [1:0] CFG_DEVICE_SPEEDS = 2'd1;
	localparam logic [1:0] CFG_DWELL_MS      = 2'd2;

	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW  = 16;

	// Reset values of the configuration registers
	localparam logic [7:0]  PORT_SPEEDS_RST   = 8'd2;
	localparam logic [7:0]  DEVICE_SPEEDS_RST = 8'd255;
	localparam logic [15:0] DWELL_MS_RST      = 16'd1000;

	// Item kinds
	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	typedef struct packed {
		logic [7:0]  port_speeds;
		logic [7:0]  device_speeds;
		logic [15:0] dwell_ms;
	} cfg_t;

	typedef struct packed {
		logic       retrain;
		logic [2:0] target_gen;
		status_t    status;
		logic       restart;  // attempt issued or invalid target: clear the dwell counter
		logic       count;    // tick that advances the dwell counter
	} decision_t;

	// Highest set bit among bits 1..7; 0 for none
	function automatic logic [2:0] top_bit(input logic [7:0] v);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (v[i]) begin
				n = 3'(i);
			end
		end
		return n;
	endfunction

endpackage

// File: hw/rtl/lsrf_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: port and device speed vectors and dwell time.
// Depends on lsrf_pkg for register indexes, reset values and cfg_t.
module lsrf_cfg_regs
	import lsrf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.port_speeds   <= PORT_SPEEDS_RST;
			cfg_q.device_speeds <= DEVICE_SPEEDS_RST;
			cfg_q.dwell_ms      <= DWELL_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PORT_SPEEDS:   cfg_q.port_speeds   <= cfg_data[7:0];
				CFG_DEVICE_SPEEDS: cfg_q.device_speeds <= cfg_data[7:0];
				CFG_DWELL_MS:      cfg_q.dwell_ms      <= cfg_data;
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/lsrf_decide.sv
`timescale 1ns / 1ps
// Decision logic for one item: step clamp, dwell and opt-in hold, target pick.
// Depends on lsrf_pkg for cfg_t, decision_t, status codes and top_bit.
module lsrf_decide
	import lsrf_pkg::*;
(
	input  cfg_t        cfg,
	input  logic        kind,
	input  logic [2:0]  requested_gen,
	input  logic [2:0]  current_gen,
	input  logic        all_opted_in,
	input  logic [15:0] elapsed_ms,
	input  logic        changed_once,
	output decision_t   dec
);

	logic [3:0] cur;
	logic [7:0] step_table;
	logic [7:0] below_mask;
	logic [2:0] step;
	logic       clamp_en;
	logic [2:0] want;
	logic       down;
	logic       dwell_open;
	logic [7:0] common;
	logic [7:0] desired;
	logic [2:0] tgt;

	always_comb begin
		// unknown current speed ranks above every generation
		cur        = (current_gen == 3'd0) ? 4'd8 : {1'b0, current_gen};
		step_table = cfg.port_speeds & 8'hFE;
		for (int i = 0; i < 8; i++) begin
			below_mask[i] = (4'(i) < cur);
		end
		step     = top_bit(step_table & below_mask);
		clamp_en = ({1'b0, requested_gen} < cur) && !cur[3] && step_table[cur[2:0]]
			&& (requested_gen != 3'd0) && step_table[requested_gen];
		want     = (clamp_en && (step > requested_gen)) ? step : requested_gen;
		down     = ({1'b0, want} < cur);
		dwell_open = (elapsed_ms < cfg.dwell_ms);

		common = cfg.port_speeds & cfg.device_speeds;
		if (common == 8'd0) begin
			common = 8'd2;
		end
		for (int i = 0; i < 8; i++) begin
			desired[i] = (i >= 1) && (3'(i) <= want);
		end
		tgt = top_bit(common & desired);
		if (tgt == 3'd0) begin
			tgt = 3'd1;
		end
	end

	always_comb begin
		dec = '{retrain: 1'b0, target_gen: 3'd0, status: ST_TICK, restart: 1'b0,
			count: 1'b0};
		priority if (kind == KIND_TICK) begin
			dec.count = dwell_open;
		end else if (down && changed_once && dwell_open) begin
			dec.status = ST_HELD;
		end else if ({1'b0, want} == cur) begin
			dec.status = ST_AT_SPEED;
		end else if (!all_opted_in) begin
			dec.status = ST_HELD;
		end else if ((want == 3'd0) || (want == 3'd7)) begin
			dec.status  = ST_INVALID;
			dec.restart = 1'b1;
		end else begin
			dec.status     = ST_ISSUED;
			dec.restart    = 1'b1;
			dec.retrain    = 1'b1;
			dec.target_gen = tgt;
		end
	end

endmodule

// File: hw/rtl/link_speed_request_filter_core.sv
`timescale 1ns / 1ps
// Link speed request filter: turns governor speed requests into retrain commands.
// Result path: the input register takes each transfer and the decision logic feeds
// the result register; a stalled result holds the item in the input register.
// Throughput: one item per cycle while out_stall is low; the decision and dwell
// counter update both complete in the single stage between the two registers.
// Reset (arst_n, async, active low): pipeline empty, dwell counter 0, no attempt
// yet, config regs at port 2, device 255, dwell 1000 ms. Uses lsrf_pkg.
module link_speed_request_filter_core
	import lsrf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [2:0]           requested_gen,
	input  logic [2:0]           current_gen,
	input  logic                 all_opted_in,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 retrain,
	output logic [2:0]           target_gen,
	output logic [2:0]           status
);

	cfg_t      cfg;
	decision_t dec;

	// input register stage
	logic       valid_s1;
	logic       kind_s1;
	logic [2:0] requested_gen_s1;
	logic [2:0] current_gen_s1;
	logic       all_opted_in_s1;

	// result register stage
	logic       valid_s2;
	logic       retrain_s2;
	logic [2:0] target_gen_s2;
	status_t    status_s2;

	// dwell state
	logic [15:0] elapsed_ms_q;
	logic        changed_once_q;

	logic in_xfer;
	logic out_xfer;
	logic advance;

	lsrf_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lsrf_decide u_decide (
		.cfg           (cfg),
		.kind          (kind_s1),
		.requested_gen (requested_gen_s1),
		.current_gen   (current_gen_s1),
		.all_opted_in  (all_opted_in_s1),
		.elapsed_ms    (elapsed_ms_q),
		.changed_once  (changed_once_q),
		.dec           (dec)
	);

	// Advance the held item whenever the result register is free or drains this
	// cycle; stall the input only when both stages are occupied and blocked.
	assign out_xfer = valid_s2 && !out_stall;
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture payload on each input transfer; hold it otherwise.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1          <= kind;
			requested_gen_s1 <= requested_gen;
			current_gen_s1   <= current_gen;
			all_opted_in_s1  <= all_opted_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_xfer) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			retrain_s2    <= dec.retrain;
			target_gen_s2 <= dec.target_gen;
			status_s2     <= dec.status;
		end
	end

	// Dwell counter: restart on every issued or invalid attempt, count ticks up to dwell.
	// Updated exactly once per item, as the item moves into the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_ms_q   <= '0;
			changed_once_q <= 1'b0;
		end else if (advance) begin
			if (dec.restart) begin
				elapsed_ms_q   <= '0;
				changed_once_q <= 1'b1;
			end else if (dec.count) begin
				elapsed_ms_q <= elapsed_ms_q + 16'd1;
			end
		end
	end

	assign out_valid  = valid_s2;
	assign retrain    = retrain_s2;
	assign target_gen = target_gen_s2;
	assign status     = 3'(status_s2);

`ifndef NO_ASSERTIONS
	// a retrain goes out exactly with the issued status
	a_retrain_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (retrain == (status == 3'(ST_ISSUED))))
		else $error("retrain flag disagrees with status");

	// no target generation unless retraining
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !retrain) |-> (target_gen == 3'd0))
		else $error("target_gen nonzero without retrain");

	// an issued or invalid attempt clears the dwell counter
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && dec.restart) |=> (elapsed_ms_q == 16'd0) && changed_once_q)
		else $error("dwell counter not restarted after attempt");

	// input is only stalled when both stages hold an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled with room in the pipeline");

	// once an attempt was issued the flag stays set until reset
	a_changed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(changed_once_q))
		else $error("changed_once cleared without reset");
`endif

endmodule
